// ===== hdl/efws_pkg.sv =====
// Shared widths, constants and state encoding for the earliest-free worker scheduler.
package efws_pkg;

   localparam int TIME_W  = 63;
   localparam int DUR_W   = 32;
   localparam int WID_W   = 6;
   localparam int COUNT_W = 7;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TOP  = 3'b010,
      ST_SIFT = 3'b100
   } state_type;

endpackage

// ===== hdl/earliest_free_worker_scheduler.sv =====
// Earliest-free worker scheduler: min-heap of worker free times kept in a two-read-port RAM.
//
// Usage:
//  - req_ channel: one beat per job (duration, restart flag). restart clears every
//    worker's free time to zero before the job is assigned.
//  - rsp_ channel: one beat per job with the chosen worker and its start time.
//  - csr_ channel: writes worker_count and reinitializes the heap. Write only while idle.
//  - Per job: the heap top is read and the result register loaded (ST_TOP); then, with
//    more than one active worker, the entry moves down the heap level by level in ST_SIFT
//    until it settles in its slot, through the sift-down loop over the heap RAM.
//  - rsp_valid is registered; it is set from ST_TOP, after the req beat, once the output is free.
//  - The next job is taken once the sift ends, even while a result still waits.
//    If the receiver stalls, a job waits at the heap top until the output frees.
//  - Reset: synchronous, active high. worker_count returns to min(MAX_WORKERS, 64), all free times read
//    as zero and slot i holds worker i; per-slot valid bits make this immediate.
module earliest_free_worker_scheduler #(
   parameter int MAX_WORKERS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [efws_pkg::DUR_W-1:0]    req_job_duration,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [efws_pkg::WID_W-1:0]    rsp_worker_id,
   output logic [efws_pkg::TIME_W-1:0]   rsp_start_time,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [efws_pkg::COUNT_W-1:0]  csr_worker_count
);
   import efws_pkg::*;

   // worker_count never exceeds 127, so deeper slots are never reached
   localparam int DEPTH   = (MAX_WORKERS < 128) ? MAX_WORKERS : 128;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDW     = AW;
   localparam int EW      = TIME_W + IDW;
   localparam int NW      = $clog2(DEPTH + 1);
   localparam int IW      = AW + 2;
   localparam int N_RESET = (MAX_WORKERS < 64) ? MAX_WORKERS : 64;

   function automatic logic slot_before(input logic [TIME_W-1:0] x_time,
                                        input logic [IDW-1:0]    x_id,
                                        input logic [TIME_W-1:0] y_time,
                                        input logic [IDW-1:0]    y_id);
      return (x_time < y_time) || ((x_time == y_time) && (x_id < y_id));
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [TIME_W-1:0]     cur_time_ff, cur_time_in;
   logic [IDW-1:0]        cur_id_ff, cur_id_in;
   logic [DUR_W-1:0]      dur_ff;
   logic [WID_W-1:0]      rsp_id_ff;
   logic [TIME_W-1:0]     rsp_time_ff;

   logic [EW-1:0]         heap_mem [DEPTH];
   logic [EW-1:0]         rd_a_ff, rd_b_ff;
   logic                  rd_a_vld_ff, rd_b_vld_ff;
   logic [AW-1:0]         rd_a_addr_ff, rd_b_addr_ff;

   logic                  rd_en;
   logic [AW-1:0]         rd_a_addr, rd_b_addr;
   logic                  mem_we;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;

   logic                  req_fire, csr_fire, heap_clear, rsp_load;
   logic [TIME_W-1:0]     a_time, b_time;
   logic [IDW-1:0]        a_id, b_id;
   logic [63:0]           finish_sum;
   logic [TIME_W-1:0]     finish;
   logic [IW-1:0]         left_idx, right_idx, pick_left_idx;
   logic                  has_right, l_b4_c, r_b4_l, r_b4_c, pick_right, move_up;
   logic [AW-1:0]         pick_addr;
   logic [TIME_W-1:0]     pick_time;
   logic [IDW-1:0]        pick_id;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign heap_clear = csr_fire || (req_fire && req_restart);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_worker_id  = rsp_id_ff;
   assign rsp_start_time = rsp_time_ff;

   // slot never written since the last clear reads as free at time zero, holding its own index
   assign a_time = rd_a_vld_ff ? rd_a_ff[EW-1:IDW] : '0;
   assign a_id   = rd_a_vld_ff ? rd_a_ff[IDW-1:0]  : rd_a_addr_ff;
   assign b_time = rd_b_vld_ff ? rd_b_ff[EW-1:IDW] : '0;
   assign b_id   = rd_b_vld_ff ? rd_b_ff[IDW-1:0]  : rd_b_addr_ff;

   assign finish_sum = {1'b0, a_time} + 64'(dur_ff);
   assign finish     = finish_sum[63] ? TIME_MAX : finish_sum[TIME_W-1:0];

   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + IW'(1);
   assign has_right = right_idx < IW'(n_ff);

   assign l_b4_c     = slot_before(a_time, a_id, cur_time_ff, cur_id_ff);
   assign r_b4_l     = slot_before(b_time, b_id, a_time, a_id);
   assign r_b4_c     = slot_before(b_time, b_id, cur_time_ff, cur_id_ff);
   assign pick_right = has_right && r_b4_l;
   assign move_up    = pick_right ? r_b4_c : l_b4_c;
   assign pick_addr  = pick_right ? rd_b_addr_ff : rd_a_addr_ff;
   assign pick_time  = pick_right ? b_time : a_time;
   assign pick_id    = pick_right ? b_id : a_id;
   assign pick_left_idx = {1'b0, pick_addr, 1'b1};

   assign rsp_load = (state_ff == ST_TOP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      valid_in     = valid_ff;
      cur_time_in  = cur_time_ff;
      cur_id_in    = cur_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      mem_we       = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = {cur_time_ff, cur_id_ff};

      if (csr_fire) begin
         if (csr_worker_count == '0) begin
            n_in = NW'(1);
         end else if (int'(csr_worker_count) > MAX_WORKERS) begin
            n_in = NW'(MAX_WORKERS);
         end else begin
            n_in = NW'(csr_worker_count);
         end
      end
      if (heap_clear) begin
         valid_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_en     = 1'b1;
               rd_a_addr = '0;
               state_in  = ST_TOP;
            end
         end
         ST_TOP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               cur_time_in  = finish;
               cur_id_in    = a_id;
               pos_in       = '0;
               if (n_ff == NW'(1)) begin
                  mem_we      = 1'b1;
                  wr_addr     = '0;
                  wr_data     = {finish, a_id};
                  valid_in[0] = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_a_addr = AW'(1);
                  rd_b_addr = AW'(2);
                  state_in  = ST_SIFT;
               end
            end
         end
         ST_SIFT: begin
            mem_we = 1'b1;
            valid_in[pos_ff] = 1'b1;
            if ((left_idx >= IW'(n_ff)) || !move_up) begin
               // entry settles here
               state_in = ST_IDLE;
            end else begin
               wr_data   = {pick_time, pick_id};
               pos_in    = pick_addr;
               rd_en     = 1'b1;
               rd_a_addr = AW'(pick_left_idx);
               rd_b_addr = AW'(pick_left_idx + IW'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         n_ff         <= NW'(N_RESET);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         n_ff         <= n_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_time_ff <= cur_time_in;
      cur_id_ff   <= cur_id_in;
      if (req_fire) begin
         dur_ff <= req_job_duration;
      end
      if (rsp_load) begin
         rsp_id_ff   <= WID_W'(a_id);
         rsp_time_ff <= a_time;
      end
      if (rd_en) begin
         rd_a_addr_ff <= rd_a_addr;
         rd_b_addr_ff <= rd_b_addr;
         rd_a_vld_ff  <= valid_ff[rd_a_addr] && !heap_clear;
         rd_b_vld_ff  <= valid_ff[rd_b_addr] && !heap_clear;
      end
   end

   // heap RAM: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= heap_mem[rd_a_addr];
         rd_b_ff <= heap_mem[rd_b_addr];
      end
   end

`ifndef NO_ASSERTIONS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_restart) |=> (valid_ff == '0))
      else $error("restart did not clear heap valid bits");

   a_csr_count_range: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> ((valid_ff == '0) && (n_ff != '0) &&
                                    (int'(n_ff) <= MAX_WORKERS)))
      else $error("worker count write left heap or count inconsistent");

   a_sift_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIFT) |-> (IW'(pos_ff) < IW'(n_ff)))
      else $error("sift position outside active heap");

   a_rsp_from_top: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_TOP))
      else $error("result raised outside heap-top read");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for the earliest-free worker scheduler: directed and random jobs vs a heap predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import efws_pkg::*;

   localparam int          HEAP_SLOTS    = 64;
   localparam int          SETTLE_CYCLES = 12;      // lets a 64-entry heap finish its sift before the write
   localparam int          TAIL_CYCLES   = 20;
   localparam longint      CYCLE_LIMIT   = 200000;
   localparam int          REPORT_MAX    = 10;
   localparam logic [DUR_W-1:0] DUR_MAX  = {DUR_W{1'b1}};

   typedef struct packed {
      logic [WID_W-1:0]  worker;
      logic [TIME_W-1:0] start;
   } assignment_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [DUR_W-1:0]    req_job_duration;
   logic                req_restart;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [WID_W-1:0]    rsp_worker_id;
   logic [TIME_W-1:0]   rsp_start_time;
   logic                csr_valid;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_worker_count;

   // predictor state
   logic [TIME_W-1:0]   free_at     [HEAP_SLOTS];
   logic [WID_W-1:0]    slot_worker [HEAP_SLOTS];
   logic [COUNT_W-1:0]  worker_count_reg;

   assignment_type      pending_assignments[$];
   int unsigned         mismatches;
   longint              cycle_count;
   bit                  idle_on;
   int unsigned         rsp_wait;
   int unsigned         rsp_hold_left;

   earliest_free_worker_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_job_duration (req_job_duration),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_worker_id    (rsp_worker_id),
      .rsp_start_time   (rsp_start_time),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_worker_count (csr_worker_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic void clear_heap();
      for (int i = 0; i < HEAP_SLOTS; i++) begin
         free_at[i]     = '0;
         slot_worker[i] = WID_W'(i);
      end
   endfunction

   function automatic int active_count();
      int n;
      n = int'(worker_count_reg);
      if (n == 0) n = 1;
      if (n > HEAP_SLOTS) n = HEAP_SLOTS;
      return n;
   endfunction

   function automatic bit orders_first(input int a, input int b);
      if (free_at[a] != free_at[b]) return free_at[a] < free_at[b];
      return slot_worker[a] < slot_worker[b];
   endfunction

   function automatic assignment_type assign_job(input logic [DUR_W-1:0] dur, input logic clear);
      assignment_type         a;
      logic [TIME_W:0]        finish;
      logic [TIME_W-1:0]      t;
      logic [WID_W-1:0]       w;
      int                     n;
      int                     pos;
      int                     left;
      int                     pick;
      if (clear) clear_heap();
      n        = active_count();
      a.worker = slot_worker[0];
      a.start  = free_at[0];
      finish   = {1'b0, a.start} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
      free_at[0] = finish[TIME_W] ? TIME_MAX : finish[TIME_W-1:0];
      pos = 0;
      forever begin
         left = 2 * pos + 1;
         if (left >= n) break;
         pick = left;
         if (left + 1 < n && orders_first(left + 1, left)) pick = left + 1;
         if (!orders_first(pick, pos)) break;
         t = free_at[pos];     free_at[pos]     = free_at[pick];     free_at[pick]     = t;
         w = slot_worker[pos]; slot_worker[pos] = slot_worker[pick]; slot_worker[pick] = w;
         pos = pick;
      end
      return a;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_job(input logic [DUR_W-1:0] dur, input logic clear);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_job_duration = dur;
      req_restart      = clear;
      do @(posedge clock); while (!req_ready);
      pending_assignments.push_back(assign_job(dur, clear));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_assignments.size() != 0) @(posedge clock);
   endtask

   task automatic write_worker_count(input logic [COUNT_W-1:0] cnt);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid        = 1'b1;
      csr_worker_count = cnt;
      do @(posedge clock); while (!csr_ready);
      worker_count_reg = cnt;
      clear_heap();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // receiver: per-beat random wait plus one long hold-off in the back-pressure test
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_ready = 1'b0;
         rsp_hold_left--;
      end else if (rsp_wait != 0) begin
         rsp_ready = 1'b0;
         rsp_wait--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // ---------------- checker ----------------
   always @(posedge clock) begin
      assignment_type exp_a;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_wait = idle_on ? $urandom_range(0, 3) : 0;
         if (pending_assignments.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("ERROR: unexpected beat worker=%0d start=%0d",
                        rsp_worker_id, rsp_start_time);
         end else begin
            exp_a = pending_assignments.pop_front();
            if (rsp_worker_id !== exp_a.worker) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("ERROR: worker_id expected %0d actual %0d",
                           exp_a.worker, rsp_worker_id);
            end
            if (rsp_start_time !== exp_a.start) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("ERROR: start_time expected %0d actual %0d (worker %0d)",
                           exp_a.start, rsp_start_time, exp_a.worker);
            end
         end
      end
   end

   // ---------------- tests ----------------
   function automatic logic [DUR_W-1:0] pick_duration();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return $urandom_range(0, 7);      // lots of ties
      if (sel < 70) return $urandom_range(0, 1000);
      if (sel < 90) return $urandom;
      return sel[0] ? DUR_MAX : '0;
   endfunction

   task automatic test_reset_defaults();
      for (int i = 0; i < 4; i++) send_job('0, 1'b0);
      send_job(DUR_MAX, 1'b0);
      send_job(32'd1, 1'b0);
   endtask

   task automatic test_duration_extremes();
      send_job(32'h5555_5555, 1'b0);
      send_job(32'hAAAA_AAAA, 1'b0);
      send_job('0, 1'b0);
      send_job(32'd1, 1'b0);
   endtask

   task automatic test_restart();
      send_job(32'd100, 1'b1);
      send_job(32'd7, 1'b1);
   endtask

   task automatic test_count_extremes();
      write_worker_count(7'd1);
      send_job(32'd10, 1'b0);
      send_job(32'd20, 1'b0);
      write_worker_count(7'd0);              // zero acts as a single worker
      send_job(32'd3, 1'b0);
      send_job(DUR_MAX, 1'b0);
      write_worker_count(7'd127);            // clamps to the heap size
      send_job(32'd5, 1'b0);
      send_job(32'd5, 1'b0);
      write_worker_count(7'd65);
      send_job(32'd9, 1'b1);
      write_worker_count(7'd2);
      send_job(32'd4, 1'b0);
      send_job(32'd2, 1'b0);
      send_job(32'd1, 1'b0);
   endtask

   task automatic test_random_phases();
      logic [COUNT_W-1:0] cnt;
      for (int phase = 0; phase < 14; phase++) begin
         case (phase)
            0:       cnt = 7'd1;
            1:       cnt = 7'd64;
            2:       cnt = 7'd0;
            3:       cnt = 7'd127;
            4, 7:    cnt = COUNT_W'($urandom_range(2, 8));
            default: cnt = COUNT_W'($urandom_range(1, 64));
         endcase
         write_worker_count(cnt);
         idle_on = (phase != 5);             // one phase at full rate
         for (int i = 0; i < 112; i++)
            send_job(pick_duration(), ($urandom_range(0, 39) == 0));
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      write_worker_count(7'd64);
      @(posedge clock);
      rsp_hold_left = 300;
      for (int i = 0; i < 40; i++) send_job(pick_duration(), 1'b0);
      wait_for_drain();                      // sender pauses until all results are in
      for (int i = 0; i < 20; i++) send_job(pick_duration(), ($urandom_range(0, 9) == 0));
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_job_duration = '0;
      req_restart      = 1'b0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_worker_count = '0;
      mismatches       = 0;
      cycle_count      = 0;
      idle_on          = 1'b1;
      rsp_wait         = 0;
      rsp_hold_left    = 0;
      worker_count_reg = 7'd64;
      clear_heap();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_duration_extremes();
      test_restart();
      test_count_extremes();
      test_random_phases();
      test_backpressure();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
